// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, active during reset too
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion, off while rst_n is low
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/rgbbmp_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbbmp_pkg
// Shared types and constants of the RGB block mean pixelate core.
// ----------------------------------------------------------------------------
package rgbbmp_pkg;

  localparam int DIM_W       = 12;
  localparam int LG_W        = 3;
  localparam int COL_W       = 11;
  localparam int SUM_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [LG_W-1:0]    lg_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [Q_PTR_W-1:0] q_ptr_t;
  typedef logic [Q_CNT_W-1:0] q_cnt_t;

  localparam dim_t RST_WIDTH  = dim_t'(640);
  localparam dim_t RST_HEIGHT = dim_t'(480);
  localparam lg_t  RST_LOG2   = lg_t'(2);
  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BLOCK_LOG2   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_mean;
    logic [7:0] green_mean;
    logic [7:0] blue_mean;
    logic [9:0] block_col;
    logic [9:0] block_row;
    logic       frame_done;
  } out_word_t;

  // clamped configuration
  typedef struct packed {
    dim_t width;
    dim_t height;
    lg_t  lg;
  } cfg_t;

  typedef struct packed {
    in_word_t pix;
    col_t     bx;
    col_t     by;
    logic     first;
    logic     last;
    logic     frame_done;
  } blk_item_t;

  typedef struct packed {
    logic      valid;
    blk_item_t item;
  } q_word_t;

endpackage

// ===== rtl/rgbbmp_ram.sv =====
// ----------------------------------------------------------------------------
// rgbbmp_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgbbmp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rgbbmp_front.sv =====
// ----------------------------------------------------------------------------
// rgbbmp_front
// Raster position tracking and block classification of incoming pixels.
// ----------------------------------------------------------------------------
module rgbbmp_front #(
  parameter int SUM_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgbbmp_pkg::cfg_t     cfg,
  input  logic                 in_valid,
  input  rgbbmp_pkg::in_word_t in_word,
  output logic                 in_stall,
  input  logic                 q_full,
  output rgbbmp_pkg::q_word_t  q_push
);

  rgbbmp_pkg::dim_t x_r, x_nxt;
  rgbbmp_pkg::dim_t y_r, y_nxt;
  rgbbmp_pkg::dim_t bx, by, full_cols, full_rows, edge_mask, ox, oy;
  logic [rgbbmp_pkg::DIM_W:0] x_inc, y_inc;
  logic accept, in_blk;

  assign accept    = in_valid && !q_full;
  assign in_stall  = q_full;

  assign bx        = x_r >> cfg.lg;
  assign by        = y_r >> cfg.lg;
  assign full_cols = cfg.width >> cfg.lg;
  assign full_rows = cfg.height >> cfg.lg;
  assign edge_mask = (rgbbmp_pkg::dim_t'(1) << cfg.lg) - rgbbmp_pkg::dim_t'(1);
  assign ox        = x_r & edge_mask;
  assign oy        = y_r & edge_mask;
  assign in_blk    = (bx < full_cols) && (by < full_rows) && (32'(bx) < SUM_DEPTH);

  always_comb begin
    q_push.valid           = accept && in_blk;
    q_push.item.pix        = in_word;
    q_push.item.bx         = rgbbmp_pkg::col_t'(bx);
    q_push.item.by         = rgbbmp_pkg::col_t'(by);
    q_push.item.first      = (ox == '0) && (oy == '0);
    q_push.item.last       = (ox == edge_mask) && (oy == edge_mask);
    q_push.item.frame_done = (bx == full_cols - rgbbmp_pkg::dim_t'(1)) &&
                             (by == full_rows - rgbbmp_pkg::dim_t'(1));
  end

  assign x_inc = {1'b0, x_r} + 1'b1;
  assign y_inc = {1'b0, y_r} + 1'b1;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (accept) begin
      if (x_inc >= {1'b0, cfg.width}) begin
        x_nxt = '0;
        y_nxt = (y_inc >= {1'b0, cfg.height}) ? '0 : y_inc[rgbbmp_pkg::DIM_W-1:0];
      end else begin
        x_nxt = x_inc[rgbbmp_pkg::DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

endmodule

// ===== rtl/rgbbmp_queue.sv =====
// ----------------------------------------------------------------------------
// rgbbmp_queue
// Short FIFO of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
module rgbbmp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbbmp_pkg::q_word_t push,
  input  logic                pop,
  output rgbbmp_pkg::q_word_t head,
  output logic                full
);

  rgbbmp_pkg::blk_item_t mem_r [rgbbmp_pkg::QUEUE_DEPTH];
  rgbbmp_pkg::q_ptr_t    wr_ptr_r, wr_ptr_nxt;
  rgbbmp_pkg::q_ptr_t    rd_ptr_r, rd_ptr_nxt;
  rgbbmp_pkg::q_cnt_t    cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full       = (cnt_r == rgbbmp_pkg::q_cnt_t'(rgbbmp_pkg::QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  assign do_push = push.valid && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

// ===== rtl/rgbbmp_back.sv =====
// ----------------------------------------------------------------------------
// rgbbmp_back
// Column sum accumulation in RAM, mean computation and output register.
// ----------------------------------------------------------------------------
module rgbbmp_back #(
  parameter int SUM_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rgbbmp_pkg::lg_t       lg,
  input  rgbbmp_pkg::q_word_t   head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgbbmp_pkg::out_word_t out_word
);

  localparam int AW = $clog2(SUM_DEPTH);
  localparam int SW = rgbbmp_pkg::SUM_W;

  function automatic logic [7:0] sat_mean(input rgbbmp_pkg::sum_t sum,
                                          input rgbbmp_pkg::lg_t  l2);
    rgbbmp_pkg::sum_t sh;
    sh = sum >> {l2, 1'b0};
    return (|sh[SW-1:8]) ? rgbbmp_pkg::SAT_MAX : sh[7:0];
  endfunction

  logic                  b_valid_r, b_valid_nxt;
  rgbbmp_pkg::blk_item_t b_item_r, b_item_nxt;
  logic                  b_fwd_r, b_fwd_nxt;
  logic [3*SW-1:0]       last_sum_r, last_sum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rgbbmp_pkg::out_word_t out_word_r, out_word_nxt;

  logic [3*SW-1:0]  rdata, old_sum, new_sum;
  rgbbmp_pkg::sum_t r_sum, g_sum, b_sum;
  logic             fire_b, load_b;

  assign fire_b = b_valid_r && (!b_item_r.last || !out_valid_r || !out_stall);
  assign load_b = head.valid && (!b_valid_r || fire_b);
  assign pop    = load_b;

  rgbbmp_ram #(
    .WIDTH (3 * SW),
    .DEPTH (SUM_DEPTH)
  ) u_sum_ram (
    .clk   (clk),
    .we    (fire_b),
    .waddr (AW'(b_item_r.bx)),
    .wdata (new_sum),
    .re    (load_b),
    .raddr (AW'(head.item.bx)),
    .rdata (rdata)
  );

  assign old_sum = b_fwd_r ? last_sum_r : rdata;

  always_comb begin
    if (b_item_r.first) begin
      r_sum = {8'd0, b_item_r.pix.red_in};
      g_sum = {8'd0, b_item_r.pix.green_in};
      b_sum = {8'd0, b_item_r.pix.blue_in};
    end else begin
      r_sum = old_sum[3*SW-1:2*SW] + {8'd0, b_item_r.pix.red_in};
      g_sum = old_sum[2*SW-1:SW]   + {8'd0, b_item_r.pix.green_in};
      b_sum = old_sum[SW-1:0]      + {8'd0, b_item_r.pix.blue_in};
    end
  end

  assign new_sum = {r_sum, g_sum, b_sum};

  always_comb begin
    b_valid_nxt   = b_valid_r;
    b_item_nxt    = b_item_r;
    b_fwd_nxt     = b_fwd_r;
    last_sum_nxt  = fire_b ? new_sum : last_sum_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (load_b) begin
      b_valid_nxt = 1'b1;
      b_item_nxt  = head.item;
      // write of the leaving item lands at the same edge as this read
      b_fwd_nxt   = fire_b && (head.item.bx == b_item_r.bx);
    end else if (fire_b) begin
      b_valid_nxt = 1'b0;
    end
    if (fire_b && b_item_r.last) begin
      out_valid_nxt           = 1'b1;
      out_word_nxt.red_mean   = sat_mean(r_sum, lg);
      out_word_nxt.green_mean = sat_mean(g_sum, lg);
      out_word_nxt.blue_mean  = sat_mean(b_sum, lg);
      out_word_nxt.block_col  = b_item_r.bx[9:0];
      out_word_nxt.block_row  = b_item_r.by[9:0];
      out_word_nxt.frame_done = b_item_r.frame_done;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_item_r   <= b_item_nxt;
    b_fwd_r    <= b_fwd_nxt;
    last_sum_r <= last_sum_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/rgb_block_mean_pixelate_core.sv =====
// ----------------------------------------------------------------------------
// rgb_block_mean_pixelate_core
// Block average pixelation of a raster RGB stream, one mean per full block.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock in raster order while in_stall is low, and
// emits one word per completed square block (edge 2**block_log2) carrying the
// mean red, green and blue and the block coordinates; partial edge blocks
// give nothing. A block's word passes the queue and the accumulator and output
// registers. The rate is set by the read-modify-write of the per-column sum
// RAM (one registered read and one write per cycle, with a one-deep bypass).
// The sum RAM has no reset and no clearing pass: each block loads it with its
// first pixel. A four-word queue between the pixel classifier and the
// accumulator absorbs output stalls. Configure only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_block_mean_pixelate_core #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_HEIGHT     = 2048,
  parameter int MAX_BLOCK_LOG2 = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [rgbbmp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgbbmp_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                   in_valid,
  input  rgbbmp_pkg::in_word_t                   in_word,
  output logic                                   in_stall,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output rgbbmp_pkg::out_word_t                  out_word
);

  localparam int SUM_DEPTH = MAX_WIDTH / 2;

  rgbbmp_pkg::dim_t width_r, width_nxt;
  rgbbmp_pkg::dim_t height_r, height_nxt;
  rgbbmp_pkg::lg_t  log2_r, log2_nxt;
  rgbbmp_pkg::cfg_t cfg;
  rgbbmp_pkg::q_word_t q_push, q_head;
  logic q_full, q_pop;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    log2_nxt   = log2_r;
    if (cfg_wr_en) begin
      unique case (rgbbmp_pkg::cfg_reg_t'(cfg_index))
        rgbbmp_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        rgbbmp_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_data;
        rgbbmp_pkg::REG_BLOCK_LOG2:   log2_nxt   = cfg_data[rgbbmp_pkg::LG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rgbbmp_pkg::RST_WIDTH;
      height_r <= rgbbmp_pkg::RST_HEIGHT;
      log2_r   <= rgbbmp_pkg::RST_LOG2;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      log2_r   <= log2_nxt;
    end
  end

  always_comb begin
    if (width_r == '0) begin
      cfg.width = rgbbmp_pkg::dim_t'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      cfg.width = rgbbmp_pkg::dim_t'(MAX_WIDTH);
    end else begin
      cfg.width = width_r;
    end
    if (height_r == '0) begin
      cfg.height = rgbbmp_pkg::dim_t'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      cfg.height = rgbbmp_pkg::dim_t'(MAX_HEIGHT);
    end else begin
      cfg.height = height_r;
    end
    if (log2_r == '0) begin
      cfg.lg = rgbbmp_pkg::lg_t'(1);
    end else if (32'(log2_r) > MAX_BLOCK_LOG2) begin
      cfg.lg = rgbbmp_pkg::lg_t'(MAX_BLOCK_LOG2);
    end else begin
      cfg.lg = log2_r;
    end
  end

  rgbbmp_front #(
    .SUM_DEPTH (SUM_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  rgbbmp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full)
  );

  rgbbmp_back #(
    .SUM_DEPTH (SUM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .lg        (cfg.lg),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/rgbbmp_checker.sv =====
// ----------------------------------------------------------------------------
// rgbbmp_checker
// Port level assertions for the pixelate core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbbmp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input rgbbmp_pkg::out_word_t out_word
);

  // a stalled result word holds
  `ASSERT_CLK_RST(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "held")

  // reset empties both sides
  `ASSERT_CLK(a_rst_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

  // input backpressure only follows a stalled result
  `ASSERT_CLK_RST(a_stall_cause, in_stall |-> $past(out_valid && out_stall), "bad in_stall")

endmodule

bind rgb_block_mean_pixelate_core rgbbmp_checker u_rgbbmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB block mean pixelate core.
// ----------------------------------------------------------------------------
// Streams raster pixels under a series of image and block settings and checks
// every block mean word. The first frames come from a table: reset values,
// clamped and extreme sizes, images smaller than a block, constant fills and a
// few settings changed partway through a frame. Random frames with random
// sizes follow. Expected words come from an in-bench block summer;
// constant-fill rows carry their means in the table. The sender idles in
// bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int DIM_MAX = 2048;
  localparam int LG_MAX  = 4;
  localparam int LIMIT   = 1000000;

  typedef enum int { FILL_CONST, FILL_ANY, FILL_HIGH, FILL_LOW } fill_t;
  typedef enum int { RX_FREE, RX_LIGHT, RX_HEAVY, RX_SPELLS } rx_mode_t;

  typedef struct {
    bit                   wr;
    int                   w;
    int                   h;
    int                   lg;
    int                   count;
    fill_t                kind;
    rgbbmp_pkg::in_word_t level;
  } phase_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [rgbbmp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  rgbbmp_pkg::dim_t                 cfg_data = '0;
  logic                             in_valid = 1'b0;
  rgbbmp_pkg::in_word_t             in_word = '0;
  logic                             in_stall;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  rgbbmp_pkg::out_word_t            out_word;

  // block summer state
  rgbbmp_pkg::sum_t red_acc   [0:DIM_MAX/2-1];
  rgbbmp_pkg::sum_t green_acc [0:DIM_MAX/2-1];
  rgbbmp_pkg::sum_t blue_acc  [0:DIM_MAX/2-1];
  rgbbmp_pkg::col_t pos_col = '0;
  rgbbmp_pkg::col_t pos_row = '0;
  rgbbmp_pkg::dim_t width_cfg = rgbbmp_pkg::RST_WIDTH;
  rgbbmp_pkg::dim_t height_cfg = rgbbmp_pkg::RST_HEIGHT;
  rgbbmp_pkg::lg_t  lg_cfg = rgbbmp_pkg::RST_LOG2;

  rgbbmp_pkg::out_word_t pending_means [$];
  bit                    known_fill = 1'b0;
  rgbbmp_pkg::in_word_t  known_pix = '0;
  int                    fail_count = 0;
  int                    cycles = 0;
  int                    burst_left = 0;
  rx_mode_t              stall_mode = RX_FREE;
  int                    mode_left = 0;
  int                    hold_left = 0;
  bit                    hold_level = 1'b0;

  phase_t plan [15] = '{
    '{1'b0, 0, 0, 0, 4, FILL_CONST, '{8'd10, 8'd200, 8'd30}},
    '{1'b1, 4, 8, 2, 0, FILL_ANY, '0},
    '{1'b1, 0, 0, 0, 0, FILL_ANY, '0},
    '{1'b1, 8, 2, 0, 0, FILL_CONST, '{8'd255, 8'd255, 8'd255}},
    '{1'b1, 2, 4095, 1, 8, FILL_CONST, '{8'd0, 8'd0, 8'd0}},
    '{1'b1, 3, 5, 2, 0, FILL_ANY, '0},
    '{1'b1, 16, 16, 7, 0, FILL_CONST, '{8'd255, 8'd0, 8'd255}},
    '{1'b1, 5, 3, 1, 0, FILL_ANY, '0},
    '{1'b1, 16, 8, 1, 40, FILL_ANY, '0},
    '{1'b1, 6, 8, 1, 0, FILL_HIGH, '0},
    '{1'b1, 4, 8, 1, 20, FILL_LOW, '0},
    '{1'b1, 4, 4, 1, 0, FILL_ANY, '0},
    '{1'b1, 8, 8, 1, 32, FILL_ANY, '0},
    '{1'b1, 8, 8, 2, 0, FILL_ANY, '0},
    '{1'b1, 2, 2, 1, 0, FILL_CONST, '{8'd128, 8'd127, 8'd1}}
  };

  rgb_block_mean_pixelate_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #6 clk = ~clk;

  function automatic int clampi(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] sat_mean(rgbbmp_pkg::sum_t s, int lg);
    rgbbmp_pkg::sum_t m;
    m = s >> (2 * lg);
    return (m > rgbbmp_pkg::SAT_MAX) ? rgbbmp_pkg::SAT_MAX : m[7:0];
  endfunction

  // one raster step: load or add the block column sums, report a full block
  function automatic void take_pixel(input rgbbmp_pkg::in_word_t px, output bit hit,
                                     output rgbbmp_pkg::out_word_t res);
    int w, h, lg, emask, full_cols, full_rows, x, y, bx, by;
    w = clampi(width_cfg, 1, DIM_MAX);
    h = clampi(height_cfg, 1, DIM_MAX);
    lg = clampi(lg_cfg, 1, LG_MAX);
    emask = (1 << lg) - 1;
    full_cols = w >> lg;
    full_rows = h >> lg;
    x = pos_col;
    y = pos_row;
    bx = x >> lg;
    by = y >> lg;
    hit = 1'b0;
    res = '0;
    if (bx < full_cols && by < full_rows) begin
      if ((x & emask) == 0 && (y & emask) == 0) begin
        red_acc[bx] = rgbbmp_pkg::sum_t'(px.red_in);
        green_acc[bx] = rgbbmp_pkg::sum_t'(px.green_in);
        blue_acc[bx] = rgbbmp_pkg::sum_t'(px.blue_in);
      end else begin
        red_acc[bx] = red_acc[bx] + px.red_in;
        green_acc[bx] = green_acc[bx] + px.green_in;
        blue_acc[bx] = blue_acc[bx] + px.blue_in;
      end
      if ((x & emask) == emask && (y & emask) == emask) begin
        hit = 1'b1;
        res.red_mean = sat_mean(red_acc[bx], lg);
        res.green_mean = sat_mean(green_acc[bx], lg);
        res.blue_mean = sat_mean(blue_acc[bx], lg);
        res.block_col = 10'(bx);
        res.block_row = 10'(by);
        res.frame_done = (bx == full_cols - 1 && by == full_rows - 1);
      end
    end
    if (x + 1 >= w) begin
      pos_col = '0;
      pos_row = (y + 1 >= h) ? rgbbmp_pkg::col_t'(0) : rgbbmp_pkg::col_t'(y + 1);
    end else begin
      pos_col = rgbbmp_pkg::col_t'(x + 1);
    end
  endfunction

  function automatic int pixels_to_frame_end();
    int w, h, x, y, n;
    w = clampi(width_cfg, 1, DIM_MAX);
    h = clampi(height_cfg, 1, DIM_MAX);
    x = pos_col;
    y = pos_row;
    n = 0;
    do begin
      if (x + 1 >= w) begin
        x = 0;
        y = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        x++;
      end
      n++;
    end while (x != 0 || y != 0);
    return n;
  endfunction

  task automatic report_field(string name, logic [9:0] expv, logic [9:0] actv);
    if (expv !== actv) begin
      fail_count++;
      if (fail_count <= 50)
        $display("%0t ns  %s: expected %0d, got %0d", $time, name, expv, actv);
    end
  endtask

  task automatic write_reg(rgbbmp_pkg::cfg_reg_t idx, rgbbmp_pkg::dim_t data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic send_pixel(rgbbmp_pkg::in_word_t px);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_means.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic run_phase(phase_t p, output int sent);
    rgbbmp_pkg::in_word_t px;
    wait_idle();
    if (p.wr) begin
      write_reg(rgbbmp_pkg::REG_IMAGE_WIDTH, rgbbmp_pkg::dim_t'(p.w));
      write_reg(rgbbmp_pkg::REG_IMAGE_HEIGHT, rgbbmp_pkg::dim_t'(p.h));
      write_reg(rgbbmp_pkg::REG_BLOCK_LOG2, rgbbmp_pkg::dim_t'(p.lg));
      cfg_wr_en <= 1'b0;
    end
    known_fill = (p.kind == FILL_CONST);
    known_pix = p.level;
    sent = (p.count != 0) ? p.count : pixels_to_frame_end();
    repeat (sent) begin
      case (p.kind)
        FILL_CONST: px = p.level;
        FILL_HIGH:  px = '{8'($urandom_range(224, 255)), 8'($urandom_range(224, 255)),
                           8'($urandom_range(224, 255))};
        FILL_LOW:   px = '{8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                           8'($urandom_range(0, 31))};
        default:    px = rgbbmp_pkg::in_word_t'(24'($urandom));
      endcase
      send_pixel(px);
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          hold_left = $urandom_range(1, 20);
          hold_level = ~hold_level;
        end
        hold_left--;
        out_stall <= hold_level;
      end
    endcase
  end

  always @(posedge clk) begin : monitor
    rgbbmp_pkg::out_word_t exp_w;
    bit                    hit;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rgbbmp_pkg::REG_IMAGE_WIDTH:  width_cfg = cfg_data;
          rgbbmp_pkg::REG_IMAGE_HEIGHT: height_cfg = cfg_data;
          rgbbmp_pkg::REG_BLOCK_LOG2:   lg_cfg = cfg_data[rgbbmp_pkg::LG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_pixel(in_word, hit, exp_w);
        if (hit) begin
          // constant fill: mean is the fill level itself
          if (known_fill) begin
            exp_w.red_mean = known_pix.red_in;
            exp_w.green_mean = known_pix.green_in;
            exp_w.blue_mean = known_pix.blue_in;
          end
          pending_means.push_back(exp_w);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          fail_count++;
          if (fail_count <= 50)
            $display("%0t ns  unexpected word: expected none, got %h", $time, out_word);
        end else begin
          exp_w = pending_means.pop_front();
          report_field("red_mean", exp_w.red_mean, out_word.red_mean);
          report_field("green_mean", exp_w.green_mean, out_word.green_mean);
          report_field("blue_mean", exp_w.blue_mean, out_word.blue_mean);
          report_field("block_col", exp_w.block_col, out_word.block_col);
          report_field("block_row", exp_w.block_row, out_word.block_row);
          report_field("frame_done", exp_w.frame_done, out_word.frame_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("rgb_block_mean_pixelate_core regression: fail");
      $finish;
    end
  end

  initial begin
    phase_t p;
    int     sent, rand_px, lg3;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (plan[i]) run_phase(plan[i], sent);

    rand_px = 0;
    while (rand_px < 230) begin
      lg3 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 2);
      p.wr = 1'b1;
      p.w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
      p.h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
      p.lg = ($urandom_range(0, 511) << 3) | lg3;
      p.count = 0;
      case ($urandom_range(0, 5))
        0:       p.kind = FILL_HIGH;
        1:       p.kind = FILL_LOW;
        default: p.kind = FILL_ANY;
      endcase
      p.level = '0;
      run_phase(p, sent);
      rand_px += sent;
    end

    wait_idle();
    if (fail_count == 0)
      $display("rgb_block_mean_pixelate_core regression: pass");
    else
      $display("rgb_block_mean_pixelate_core regression: fail");
    $finish;
  end

endmodule
